// ===== sv/p2bs_pkg.sv =====
package p2bs_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_GRAD = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_MAX       = 2'd0,
        MODE_AVG_VALID = 2'd1,
        MODE_AVG_AREA  = 2'd2,
        MODE_SUM       = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_POOL_MODE = 3'd0,
        REG_KERNEL_H  = 3'd1,
        REG_KERNEL_W  = 3'd2,
        REG_STRIDE_H  = 3'd3,
        REG_STRIDE_W  = 3'd4,
        REG_PAD_H     = 3'd5,
        REG_PAD_W     = 3'd6,
        REG_SPARE     = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        ADDR_TAP   = 2'd0,
        ADDR_BEST  = 2'd1,
        ADDR_ITEM  = 2'd2,
        ADDR_CLEAR = 2'd3
    } addr_sel_t;

    localparam int CFG_DATA_W = 4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [31:0] grad_value;
        logic [5:0]         out_row;
        logic [5:0]         out_col;
    } out_t;

    typedef struct packed {
        logic      load_item;
        logic      setup;
        logic      count_step;
        logic      div_start;
        logic      div_step;
        logic      tap_reset;
        logic      tap_advance;
        logic      act_write;
        logic      act_read;
        logic      grad_read;
        logic      grad_write;
        logic      write_zero;
        addr_sel_t addr_sel;
        logic      clear_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  in_plane;
        logic  empty;
        logic  mode_max;
        logic  count_done;
        logic  div_done;
        logic  tap_last;
        logic  clear_last;
        logic  out_busy;
    } status_t;

endpackage

// ===== sv/p2bs_ctrl.sv =====
module p2bs_ctrl
    import p2bs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_ACT_WR, ST_COUNT, ST_CHECK,
        ST_MSCAN, ST_MTAIL, ST_GRD, ST_GWR, ST_DIV, ST_ARD, ST_AWR,
        ST_RRD, ST_RWR
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    assign s_ready = ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.addr_sel = ADDR_TAP;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                cmd.grad_write = 1'b1;
                cmd.write_zero = 1'b1;
                cmd.addr_sel = ADDR_CLEAR;
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.kind)
                    KIND_LOAD: state_next = ST_ACT_WR;
                    KIND_GRAD: begin
                        cmd.setup = 1'b1;
                        state_next = ST_COUNT;
                    end
                    KIND_READ: state_next = ST_RRD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_ACT_WR: begin
                cmd.act_write = status.in_plane;
                state_next = ST_IDLE;
            end
            ST_COUNT: begin
                cmd.count_step = 1'b1;
                if (status.count_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.tap_reset = 1'b1;
                priority if (status.empty) begin
                    state_next = ST_IDLE;
                end else if (status.mode_max) begin
                    state_next = ST_MSCAN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_MSCAN: begin
                cmd.act_read = 1'b1;
                cmd.tap_advance = 1'b1;
                if (status.tap_last) state_next = ST_MTAIL;
            end
            ST_MTAIL: state_next = ST_GRD;
            ST_GRD: begin
                cmd.grad_read = 1'b1;
                cmd.addr_sel = ADDR_BEST;
                state_next = ST_GWR;
            end
            ST_GWR: begin
                cmd.grad_write = 1'b1;
                cmd.addr_sel = ADDR_BEST;
                state_next = ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) state_next = ST_ARD;
            end
            ST_ARD: begin
                cmd.grad_read = 1'b1;
                state_next = ST_AWR;
            end
            ST_AWR: begin
                cmd.grad_write = 1'b1;
                cmd.tap_advance = 1'b1;
                state_next = status.tap_last ? ST_IDLE : ST_ARD;
            end
            ST_RRD: begin
                cmd.grad_read = status.in_plane;
                cmd.addr_sel = ADDR_ITEM;
                state_next = ST_RWR;
            end
            ST_RWR: begin
                cmd.addr_sel = ADDR_ITEM;
                // hold until the output register can take the beat
                if (!status.out_busy) begin
                    cmd.grad_write = status.in_plane;
                    cmd.write_zero = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// ===== sv/p2bs_dp.sv =====
module p2bs_dp
    import p2bs_pkg::*;
#(
    parameter int IN_H  = 32,
    parameter int IN_W  = 32,
    parameter int DIL_H = 1,
    parameter int DIL_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_t                   s_data,
    output out_t                  m_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status
);

    localparam int PLANE = IN_H * IN_W;
    localparam int AW    = (PLANE > 1) ? $clog2(PLANE) : 1;

    logic [1:0] mode_reg;
    logic [3:0] kh_reg, kw_reg, sh_reg, sw_reg;
    logic [2:0] ph_reg, pw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MAX;
            kh_reg <= 4'd2;
            kw_reg <= 4'd2;
            sh_reg <= 4'd2;
            sw_reg <= 4'd2;
            ph_reg <= 3'd0;
            pw_reg <= 3'd0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_POOL_MODE: mode_reg <= cfg_data[1:0];
                REG_KERNEL_H:  kh_reg <= cfg_data[3:0];
                REG_KERNEL_W:  kw_reg <= cfg_data[3:0];
                REG_STRIDE_H:  sh_reg <= cfg_data[3:0];
                REG_STRIDE_W:  sw_reg <= cfg_data[3:0];
                REG_PAD_H:     ph_reg <= cfg_data[2:0];
                REG_PAD_W:     pw_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    in_t item_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
    end

    logic          in_plane;
    logic [13:0]   item_addr_w;
    assign in_plane = (7'(item_reg.row) < 7'(IN_H)) && (7'(item_reg.col) < 7'(IN_W));
    assign item_addr_w = 14'(item_reg.row) * 14'(IN_W) + 14'(item_reg.col);

    // window extent along both axes, one tap index per cycle
    logic signed [11:0] st_r_reg, st_c_reg;
    logic [3:0] t_reg, nr_reg, nc_reg;
    logic [5:0] r0_reg, c0_reg;
    logic signed [11:0] pos_r, pos_c;
    logic vr, vc;

    assign pos_r = st_r_reg + $signed(12'(t_reg) * 12'(DIL_H));
    assign pos_c = st_c_reg + $signed(12'(t_reg) * 12'(DIL_W));
    assign vr = (t_reg < kh_reg) && !pos_r[11] && (pos_r < $signed(12'(IN_H)));
    assign vc = (t_reg < kw_reg) && !pos_c[11] && (pos_c < $signed(12'(IN_W)));

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            st_r_reg <= $signed(12'(item_reg.row) * 12'(sh_reg)) - $signed(12'(ph_reg));
            st_c_reg <= $signed(12'(item_reg.col) * 12'(sw_reg)) - $signed(12'(pw_reg));
            t_reg <= '0;
            nr_reg <= '0;
            nc_reg <= '0;
            r0_reg <= '0;
            c0_reg <= '0;
        end else if (cmd.count_step) begin
            t_reg <= t_reg + 4'd1;
            if (vr) begin
                nr_reg <= nr_reg + 4'd1;
                if (nr_reg == 4'd0) r0_reg <= pos_r[5:0];
            end
            if (vc) begin
                nc_reg <= nc_reg + 4'd1;
                if (nc_reg == 4'd0) c0_reg <= pos_c[5:0];
            end
        end
    end

    // tap walk
    logic [3:0]    i_reg, j_reg;
    logic [7:0]    tap_r, tap_c;
    logic [13:0]   tap_addr_w;
    logic          tap_last;
    assign tap_r = 8'(r0_reg) + 8'(i_reg) * 8'(DIL_H);
    assign tap_c = 8'(c0_reg) + 8'(j_reg) * 8'(DIL_W);
    assign tap_addr_w = 14'(tap_r) * 14'(IN_W) + 14'(tap_c);
    assign tap_last = (i_reg == nr_reg - 4'd1) && (j_reg == nc_reg - 4'd1);

    always_ff @(posedge aclk) begin
        if (cmd.tap_reset) begin
            i_reg <= '0;
            j_reg <= '0;
        end else if (cmd.tap_advance) begin
            if (j_reg == nc_reg - 4'd1) begin
                j_reg <= '0;
                i_reg <= i_reg + 4'd1;
            end else begin
                j_reg <= j_reg + 4'd1;
            end
        end
    end

    // activation store and running maximum
    logic signed [31:0] act_mem [PLANE];
    logic signed [31:0] act_rd_reg;
    logic [AW-1:0]      cmp_addr_reg, best_addr_reg;
    logic               cmp_v_reg, first_reg;
    logic signed [31:0] best_reg;

    always_ff @(posedge aclk) begin
        if (cmd.act_write) act_mem[item_addr_w[AW-1:0]] <= item_reg.sample;
        if (cmd.act_read) act_rd_reg <= act_mem[tap_addr_w[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_v_reg <= 1'b0;
        end else begin
            cmp_v_reg <= cmd.act_read;
        end
        cmp_addr_reg <= tap_addr_w[AW-1:0];
        if (cmd.tap_reset) begin
            first_reg <= 1'b1;
        end else if (cmp_v_reg) begin
            first_reg <= 1'b0;
            if (first_reg || act_rd_reg > best_reg) begin
                best_reg <= act_rd_reg;
                best_addr_reg <= cmp_addr_reg;
            end
        end
    end

    // serial restoring divider on the gradient magnitude
    logic [31:0] dvd_reg;
    logic [7:0]  rem_reg, dsr_reg, dsr_next;
    logic [4:0]  dcnt_reg;
    logic        neg_reg;
    logic [8:0]  trial;
    logic        qbit;
    logic signed [31:0] q_val, add_val;

    always_comb begin
        unique case (mode_t'(mode_reg))
            MODE_AVG_VALID: dsr_next = 8'(nr_reg) * 8'(nc_reg);
            MODE_AVG_AREA:  dsr_next = 8'(kh_reg) * 8'(kw_reg);
            default:        dsr_next = 8'd1;
        endcase
    end

    assign trial = {rem_reg, dvd_reg[31]};
    assign qbit = (trial >= {1'b0, dsr_reg});
    assign q_val = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
    assign add_val = (mode_t'(mode_reg) == MODE_MAX) ? item_reg.sample : q_val;

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= item_reg.sample[31];
            dvd_reg <= item_reg.sample[31] ? 32'(-item_reg.sample) : item_reg.sample;
            rem_reg <= '0;
            dcnt_reg <= '0;
            dsr_reg <= dsr_next;
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? 8'(trial - {1'b0, dsr_reg}) : trial[7:0];
            dvd_reg <= {dvd_reg[30:0], qbit};
            dcnt_reg <= dcnt_reg + 5'd1;
        end
    end

    // gradient store
    logic signed [31:0] grad_mem [PLANE];
    logic signed [31:0] grad_rd_reg, grad_wdata;
    logic signed [32:0] sum;
    logic [AW-1:0]      gaddr, clr_reg;

    always_comb begin
        unique case (cmd.addr_sel)
            ADDR_TAP:   gaddr = tap_addr_w[AW-1:0];
            ADDR_BEST:  gaddr = best_addr_reg;
            ADDR_ITEM:  gaddr = item_addr_w[AW-1:0];
            ADDR_CLEAR: gaddr = clr_reg;
            default:    gaddr = clr_reg;
        endcase
    end

    assign sum = {grad_rd_reg[31], grad_rd_reg} + {add_val[31], add_val};
    always_comb begin
        priority if (cmd.write_zero) grad_wdata = '0;
        else if (sum[32] != sum[31]) grad_wdata = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else grad_wdata = sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.grad_write) grad_mem[gaddr] <= grad_wdata;
        if (cmd.grad_read) grad_rd_reg <= grad_mem[gaddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (cmd.clear_step) clr_reg <= clr_reg + 1'b1;
    end

    // result register
    logic m_valid_reg;
    out_t out_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_reg.grad_value <= in_plane ? grad_rd_reg : 32'sd0;
            out_reg.out_row <= item_reg.row;
            out_reg.out_col <= item_reg.col;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    assign status.kind = kind_t'(item_reg.kind);
    assign status.in_plane = in_plane;
    assign status.empty = (nr_reg == 4'd0) || (nc_reg == 4'd0);
    assign status.mode_max = (mode_t'(mode_reg) == MODE_MAX);
    assign status.count_done = (t_reg == 4'd15);
    assign status.div_done = (dcnt_reg == 5'd31);
    assign status.tap_last = tap_last;
    assign status.clear_last = (clr_reg == AW'(PLANE - 1));
    assign status.out_busy = m_valid_reg && !m_ready;

endmodule

// ===== sv/pool2d_backward_scatter_unit.sv =====
// Backward pass of 2D pooling over one IN_H x IN_W plane.
// Input channel s_valid/s_ready/s_data carries one beat per command:
// kind 0 loads an activation, kind 1 scatters an output gradient over its
// clipped, dilated window, kind 2 reads one gradient out and clears it.
// Only kind 2 produces a beat on m_valid/m_ready/m_data.
// Items are processed one at a time, with s_ready low from an accept
// until the item is done; a kind 2 item also waits while an earlier
// result beat is stalled. Kind 1 runs the window count walk, then in max
// mode a scan of the valid taps and a read-modify-write of the largest,
// or in avg/sum mode the serial divider and a single-port gradient
// read-modify-write of every valid tap. Result beats sit in an output
// register, so a stalled receiver only holds a later kind 2 item, not
// the items before it. After reset the gradient store is swept to zero,
// one entry per cycle, with s_ready low; configuration writes on
// cfg_we/cfg_index/cfg_data are taken at any time and apply at once.
// Registers come up as max mode, 2x2 kernel, 2x2 stride, no padding.
module pool2d_backward_scatter_unit
    import p2bs_pkg::*;
#(
    parameter int IN_H  = 32,
    parameter int IN_W  = 32,
    parameter int DIL_H = 1,
    parameter int DIL_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    p2bs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    p2bs_dp #(
        .IN_H  (IN_H),
        .IN_W  (IN_W),
        .DIL_H (DIL_H),
        .DIL_W (DIL_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/p2bs_checker.sv =====
module p2bs_checker
    import p2bs_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // one item at a time: ready drops after every accepted beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result beat appeared while block was idle");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("channel active right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

endmodule

bind pool2d_backward_scatter_unit p2bs_checker u_p2bs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import p2bs_pkg::*;

    localparam int IN_H  = 32;
    localparam int IN_W  = 32;
    localparam int DIL_H = 1;
    localparam int DIL_W = 1;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 300;

    class grad_scoreboard;
        int    act_mem[IN_H*IN_W];
        int    grad_mem[IN_H*IN_W];
        mode_t mode;
        int    kh, kw, sh, sw, ph, pw;
        out_t  pending_reads[$];
        int    errors;

        function new();
            foreach (grad_mem[i]) begin
                grad_mem[i] = 0;
                act_mem[i]  = 0;
            end
            mode = MODE_MAX;
            kh = 2; kw = 2; sh = 2; sw = 2; ph = 0; pw = 0;
            errors = 0;
        endfunction

        function void set_reg(reg_index_t idx, int v);
            case (idx)
                REG_POOL_MODE: mode = mode_t'(v[1:0]);
                REG_KERNEL_H:  kh = v & 15;
                REG_KERNEL_W:  kw = v & 15;
                REG_STRIDE_H:  sh = v & 15;
                REG_STRIDE_W:  sw = v & 15;
                REG_PAD_H:     ph = v & 7;
                REG_PAD_W:     pw = v & 7;
                default: ;
            endcase
        endfunction

        function void axis_span(int opos, int k, int s, int p, int dil, int lim,
                                output int first, output int count);
            int st;
            int pos;
            st = opos * s - p;
            first = 0;
            count = 0;
            for (int t = 0; t < k; t++) begin
                pos = st + t * dil;
                if (pos >= 0 && pos < lim) begin
                    if (count == 0) first = pos;
                    count++;
                end
            end
        endfunction

        function void add_sat(int r, int c, int v);
            longint sum;
            sum = longint'(grad_mem[r*IN_W+c]) + longint'(v);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            grad_mem[r*IN_W+c] = int'(sum);
        endfunction

        function void scatter(int orow, int ocol, int g);
            int     r0, nr, c0, nc, br, bc, best, a;
            longint q, div;
            axis_span(orow, kh, sh, ph, DIL_H, IN_H, r0, nr);
            axis_span(ocol, kw, sw, pw, DIL_W, IN_W, c0, nc);
            if (nr == 0 || nc == 0) return;
            if (mode == MODE_MAX) begin
                br = r0;
                bc = c0;
                best = act_mem[r0*IN_W+c0];
                for (int i = 0; i < nr; i++)
                    for (int j = 0; j < nc; j++) begin
                        a = act_mem[(r0+i*DIL_H)*IN_W + c0+j*DIL_W];
                        if (a > best) begin
                            best = a;
                            br = r0 + i*DIL_H;
                            bc = c0 + j*DIL_W;
                        end
                    end
                add_sat(br, bc, g);
            end else begin
                q = g;
                div = 1;
                if (mode == MODE_AVG_VALID) div = nr * nc;
                else if (mode == MODE_AVG_AREA) div = kh * kw;
                if (div > 1) q = q / div;
                for (int i = 0; i < nr; i++)
                    for (int j = 0; j < nc; j++)
                        add_sat(r0+i*DIL_H, c0+j*DIL_W, int'(q));
            end
        endfunction

        function void note_input(in_t it);
            bit   in_plane;
            out_t rd;
            in_plane = it.row < IN_H && it.col < IN_W;
            if (it.kind == KIND_LOAD) begin
                if (in_plane) act_mem[it.row*IN_W+it.col] = it.sample;
            end else if (it.kind == KIND_GRAD) begin
                scatter(it.row, it.col, it.sample);
            end else if (it.kind == KIND_READ) begin
                rd.grad_value = 0;
                if (in_plane) begin
                    rd.grad_value = grad_mem[it.row*IN_W+it.col];
                    grad_mem[it.row*IN_W+it.col] = 0;
                end
                rd.out_row = it.row;
                rd.out_col = it.col;
                pending_reads.push_back(rd);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending_reads.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: %p", got);
                return;
            end
            want = pending_reads.pop_front();
            if (got.grad_value !== want.grad_value || got.out_row !== want.out_row ||
                got.out_col !== want.out_col) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at (%0d,%0d): expected %0d (%0d,%0d), got %0d (%0d,%0d)",
                             want.out_row, want.out_col, want.grad_value, want.out_row,
                             want.out_col, got.grad_value, got.out_row, got.out_col);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_we;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    grad_scoreboard sb;
    bit             written[IN_H*IN_W];
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_cycles;
    int             quiet_cycles;

    pool2d_backward_scatter_unit #(
        .IN_H(IN_H), .IN_W(IN_W), .DIL_H(DIL_H), .DIL_W(DIL_W)
    ) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver: check beats, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_item(in_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        if (it.kind == KIND_LOAD && it.row < IN_H && it.col < IN_W)
            written[it.row*IN_W+it.col] = 1'b1;
    endtask

    task automatic send_fields(kind_t k, int r, int c, int v);
        in_t it;
        it.kind = k;
        it.row = 6'(r);
        it.col = 6'(c);
        it.sample = v;
        send_item(it);
    endtask

    task automatic write_reg(reg_index_t idx, int v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge aclk);
        sb.set_reg(idx, v);
        cfg_we <= 1'b0;
    endtask

    // drain: all reads back, then let a last scatter finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_reads.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(int md, int kh, int kw, int sh, int sw, int ph, int pw);
        wait_idle();
        write_reg(REG_POOL_MODE, md);
        write_reg(REG_KERNEL_H, kh);
        write_reg(REG_KERNEL_W, kw);
        write_reg(REG_STRIDE_H, sh);
        write_reg(REG_STRIDE_W, sw);
        write_reg(REG_PAD_H, ph);
        write_reg(REG_PAD_W, pw);
    endtask

    function automatic int pick_sample();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 32'h7fffffff;
        if (p == 1) return 32'h80000000;
        if (p == 2) return 0;
        return $urandom;
    endfunction

    function automatic int pick_pos();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(IN_H, 63) : $urandom_range(0, IN_H-1);
    endfunction

    function automatic in_t make_item();
        in_t it;
        int  p, r0, nr, c0, nc, lim_r, lim_c;
        p = $urandom_range(0, 99);
        it.sample = pick_sample();
        it.row = 6'(pick_pos());
        it.col = 6'(pick_pos());
        if (p < 30) begin
            it.kind = KIND_LOAD;
        end else if (p < 65) begin
            it.kind = KIND_GRAD;
            lim_r = (IN_H + sb.ph) / sb.sh + 1;
            lim_c = (IN_W + sb.pw) / sb.sw + 1;
            it.row = 6'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, lim_r));
            it.col = 6'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, lim_c));
            if (sb.mode == MODE_MAX) begin
                sb.axis_span(it.row, sb.kh, sb.sh, sb.ph, DIL_H, IN_H, r0, nr);
                sb.axis_span(it.col, sb.kw, sb.sw, sb.pw, DIL_W, IN_W, c0, nc);
                // load an unwritten tap first instead of reading it
                for (int i = nr - 1; i >= 0; i--)
                    for (int j = nc - 1; j >= 0; j--)
                        if (!written[(r0+i*DIL_H)*IN_W + c0+j*DIL_W]) begin
                            it.kind = KIND_LOAD;
                            it.row = 6'(r0 + i*DIL_H);
                            it.col = 6'(c0 + j*DIL_W);
                        end
            end
        end else if (p < 95) begin
            it.kind = KIND_READ;
        end else begin
            it.kind = KIND_NONE;
        end
        return it;
    endfunction

    initial begin
        int settings[8][7] = '{
            '{0, 2, 2, 2, 2, 0, 0}, '{1, 8, 8, 1, 1, 7, 7}, '{2, 3, 5, 2, 3, 1, 2},
            '{3, 1, 1, 8, 8, 0, 0}, '{0, 8, 1, 1, 8, 7, 0}, '{3, 8, 8, 8, 8, 7, 7},
            '{1, 1, 8, 3, 1, 0, 7}, '{0, 3, 3, 1, 1, 2, 2}};
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_POOL_MODE;
        cfg_data = '0;
        send_idle_pct = 29;
        recv_idle_pct = 56;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: default 2x2 max pooling
        send_fields(KIND_LOAD, 0, 0, 32'h7fffffff);
        send_fields(KIND_LOAD, 0, 1, 32'h80000000);
        send_fields(KIND_LOAD, 1, 0, 0);
        send_fields(KIND_LOAD, 1, 1, 32'h7fffffff);
        send_fields(KIND_LOAD, 40, 5, 123);
        send_fields(KIND_LOAD, 5, 63, 456);
        send_fields(KIND_GRAD, 0, 0, 32'h7fffffff);
        send_fields(KIND_GRAD, 0, 0, 32'h7fffffff);
        send_fields(KIND_GRAD, 20, 20, -5);
        send_fields(KIND_GRAD, 63, 63, 7);
        send_fields(KIND_READ, 0, 0, 0);
        send_fields(KIND_READ, 0, 0, 0);
        send_fields(KIND_READ, 1, 1, 32'h12345678);
        send_fields(KIND_READ, 63, 63, 0);
        send_fields(KIND_READ, 0, 40, 0);
        send_fields(KIND_NONE, 3, 3, 32'hffffffff);
        send_fields(KIND_READ, 31, 31, 0);

        for (int ph = 0; ph < 8; ph++) begin
            apply_setting(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3],
                          settings[ph][4], settings[ph][5], settings[ph][6]);
            if (ph < 3) begin
                send_idle_pct = 29;
                recv_idle_pct = 56;
            end else if (ph < 6) begin
                send_idle_pct = 56;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 6) hold_cycles = 2000;
            for (int n = 0; n < 165; n++) send_item(make_item());
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
